/* hdl/vced_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the vibration cycle-end detector.
// Used by every module under hdl; depends on nothing else.
package vced_pkg;

    localparam int unsigned WinW   = 4;
    localparam int unsigned ThrW   = 4;
    localparam int unsigned QuietW = 16;
    localparam int unsigned AddrW  = 4;
    localparam int unsigned DataW  = 32;

    localparam logic [WinW-1:0]   WIN_LEN_RST   = 4'd10;
    localparam logic [ThrW-1:0]   VOTE_THR_RST  = 4'd4;
    localparam logic [QuietW-1:0] QUIET_LIM_RST = 16'd600;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WINDOW_LEN     = 2'd0;
    localparam logic [1:0] REG_VOTE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_QUIET_LIMIT    = 2'd2;

    // Phase codes as seen on the result port.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_ACTIVE   = 2'd1;
    localparam logic [1:0] PH_WAITING  = 2'd2;
    localparam logic [1:0] PH_COMPLETE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_ACTIVE   = 4'b0010,
        ST_WAITING  = 4'b0100,
        ST_COMPLETE = 4'b1000
    } phase_state_t;

    typedef struct packed {
        logic win_end;
        logic vib;
    } decision_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       start;
        logic       done;
    } phase_res_t;

endpackage

/* hdl/vibration_cycle_end_detector_top.sv */
`timescale 1ns / 1ps
// Top level of the vibration cycle-end detector: handshakes and result register.
// Depends on vced_pkg, vced_cfg, vced_window and vced_phase.
//
// Each transfer on the input carries one pin sample, and a new sample can be
// taken on every clock while in_ready is high. Every window_len samples the
// block produces one result, held in an output register until taken. While that
// result waits, samples that do not close a window are still taken; a sample that
// would close the next window waits until the output register is free.
// Configuration should only be written while the block is idle.
module vibration_cycle_end_detector_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vced_pkg::AddrW-1:0]     paddr,
    input  logic [vced_pkg::DataW-1:0]     pwdata,
    output logic [vced_pkg::DataW-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           pin_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           vibration,
    output logic [1:0]                     phase,
    output logic                           cycle_begin,
    output logic                           cycle_done
);

    logic [vced_pkg::WinW-1:0]   window_len;
    logic [vced_pkg::ThrW-1:0]   vote_threshold;
    logic [vced_pkg::QuietW-1:0] quiet_limit;
    vced_pkg::decision_t         dec;
    vced_pkg::phase_res_t        pres;
    logic                        step;
    logic                        decide;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        vib_reg;
    logic [1:0]                  phase_reg;
    logic                        start_reg;
    logic                        done_reg;

    vced_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .window_len     (window_len),
        .vote_threshold (vote_threshold),
        .quiet_limit    (quiet_limit)
    );

    vced_window u_window
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .pin_level      (pin_level),
        .window_len     (window_len),
        .vote_threshold (vote_threshold),
        .dec            (dec)
    );

    vced_phase u_phase
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .decide      (decide),
        .vib         (dec.vib),
        .quiet_limit (quiet_limit),
        .res         (pres)
    );

    assign in_ready = !out_valid_reg || out_ready || !dec.win_end;
    assign step     = in_valid && in_ready;
    assign decide   = step && dec.win_end;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (decide)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            vib_reg   <= dec.vib;
            phase_reg <= pres.phase;
            start_reg <= pres.start;
            done_reg  <= pres.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vibration   = vib_reg;
    assign phase       = phase_reg;
    assign cycle_begin = start_reg;
    assign cycle_done  = done_reg;

    // A sample that closes a window must never overwrite a result still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && step) |-> !dec.win_end)
        else $error("window closed while result register was full");

    // A cycle start is only reported on a vibrating window that lands in active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cycle_begin) |-> (vibration && phase == vced_pkg::PH_ACTIVE))
        else $error("cycle_begin with inconsistent phase or vote");

    // Completion comes only from a quiet window and leaves the machine in complete.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cycle_done) |-> (!vibration && phase == vced_pkg::PH_COMPLETE
                                       && !cycle_begin))
        else $error("cycle_done with inconsistent phase or vote");

    // A decision always produces a visible result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        decide |=> out_valid)
        else $error("window decision lost");

endmodule

/* hdl/vced_cfg.sv */
`timescale 1ns / 1ps
// APB-style configuration registers: window length, vote threshold, quiet limit.
// Depends on vced_pkg.
module vced_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vced_pkg::AddrW-1:0]     paddr,
    input  logic [vced_pkg::DataW-1:0]     pwdata,
    output logic [vced_pkg::DataW-1:0]     prdata,
    output logic                           pready,
    output logic [vced_pkg::WinW-1:0]      window_len,
    output logic [vced_pkg::ThrW-1:0]      vote_threshold,
    output logic [vced_pkg::QuietW-1:0]    quiet_limit
);

    logic [vced_pkg::WinW-1:0]   win_len_reg;
    logic [vced_pkg::ThrW-1:0]   vote_thr_reg;
    logic [vced_pkg::QuietW-1:0] quiet_lim_reg;
    logic [1:0]                  reg_idx;
    logic                        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg   <= vced_pkg::WIN_LEN_RST;
            vote_thr_reg  <= vced_pkg::VOTE_THR_RST;
            quiet_lim_reg <= vced_pkg::QUIET_LIM_RST;
        end
        else if (wr_en)
        begin
            if (reg_idx == vced_pkg::REG_WINDOW_LEN)
            begin
                win_len_reg <= pwdata[vced_pkg::WinW-1:0];
            end
            if (reg_idx == vced_pkg::REG_VOTE_THRESHOLD)
            begin
                vote_thr_reg <= pwdata[vced_pkg::ThrW-1:0];
            end
            if (reg_idx == vced_pkg::REG_QUIET_LIMIT)
            begin
                quiet_lim_reg <= pwdata[vced_pkg::QuietW-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            vced_pkg::REG_WINDOW_LEN:
            begin
                prdata[vced_pkg::WinW-1:0] = win_len_reg;
            end
            vced_pkg::REG_VOTE_THRESHOLD:
            begin
                prdata[vced_pkg::ThrW-1:0] = vote_thr_reg;
            end
            vced_pkg::REG_QUIET_LIMIT:
            begin
                prdata[vced_pkg::QuietW-1:0] = quiet_lim_reg;
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign window_len     = win_len_reg;
    assign vote_threshold = vote_thr_reg;
    assign quiet_limit    = quiet_lim_reg;

endmodule

/* hdl/vced_window.sv */
`timescale 1ns / 1ps
// Sample window: counts low pin samples and makes the vote at each window end.
// Depends on vced_pkg.
module vced_window
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        pin_level,
    input  logic [vced_pkg::WinW-1:0]   window_len,
    input  logic [vced_pkg::ThrW-1:0]   vote_threshold,
    output vced_pkg::decision_t         dec
);

    logic [vced_pkg::WinW-1:0] pos_reg;
    logic [vced_pkg::WinW-1:0] pos_next;
    logic [vced_pkg::ThrW-1:0] low_reg;
    logic [vced_pkg::ThrW-1:0] low_next;
    logic [vced_pkg::ThrW-1:0] low_inc;
    logic [vced_pkg::WinW-1:0] len_eff;
    logic [vced_pkg::WinW:0]   pos_inc;

    // A zero length behaves as one sample per window.
    assign len_eff = (window_len == '0) ? vced_pkg::WinW'(1) : window_len;
    assign pos_inc = {1'b0, pos_reg} + (vced_pkg::WinW+1)'(1);

    // The window end is known before the sample arrives; it clears the counters and marks a decision.
    assign dec.win_end = (pos_inc >= {1'b0, len_eff});
    assign low_inc     = (!pin_level && (low_reg != '1)) ? low_reg + vced_pkg::ThrW'(1)
                                                         : low_reg;
    assign dec.vib     = (low_inc >= vote_threshold);

    always_comb
    begin
        pos_next = pos_reg;
        low_next = low_reg;
        if (step)
        begin
            if (dec.win_end)
            begin
                pos_next = '0;
                low_next = '0;
            end
            else
            begin
                pos_next = pos_inc[vced_pkg::WinW-1:0];
                low_next = low_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            low_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            low_reg <= low_next;
        end
    end

endmodule

/* hdl/vced_phase.sv */
`timescale 1ns / 1ps
// Four-phase cycle machine with the saturating quiet counter.
// Depends on vced_pkg.
module vced_phase
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          decide,
    input  logic                          vib,
    input  logic [vced_pkg::QuietW-1:0]   quiet_limit,
    output vced_pkg::phase_res_t          res
);

    vced_pkg::phase_state_t      state_reg;
    vced_pkg::phase_state_t      state_next;
    logic [vced_pkg::QuietW-1:0] quiet_reg;
    logic [vced_pkg::QuietW-1:0] quiet_next;
    logic [vced_pkg::QuietW-1:0] quiet_inc;
    logic                        start;
    logic                        done;

    assign quiet_inc = (quiet_reg != '1) ? quiet_reg + vced_pkg::QuietW'(1) : quiet_reg;

    always_comb
    begin
        state_next = state_reg;
        quiet_next = quiet_reg;
        start      = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            vced_pkg::ST_IDLE:
            begin
                if (vib)
                begin
                    state_next = vced_pkg::ST_ACTIVE;
                    start      = 1'b1;
                end
            end
            vced_pkg::ST_ACTIVE:
            begin
                if (!vib)
                begin
                    state_next = vced_pkg::ST_WAITING;
                    quiet_next = '0;
                end
            end
            vced_pkg::ST_WAITING:
            begin
                if (vib)
                begin
                    state_next = vced_pkg::ST_ACTIVE;
                end
                else
                begin
                    quiet_next = quiet_inc;
                    if (quiet_inc > quiet_limit)
                    begin
                        state_next = vced_pkg::ST_COMPLETE;
                        done       = 1'b1;
                    end
                end
            end
            vced_pkg::ST_COMPLETE:
            begin
                state_next = vced_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vced_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_next)
            vced_pkg::ST_IDLE:     res.phase = vced_pkg::PH_IDLE;
            vced_pkg::ST_ACTIVE:   res.phase = vced_pkg::PH_ACTIVE;
            vced_pkg::ST_WAITING:  res.phase = vced_pkg::PH_WAITING;
            vced_pkg::ST_COMPLETE: res.phase = vced_pkg::PH_COMPLETE;
            default:               res.phase = vced_pkg::PH_IDLE;
        endcase
    end

    assign res.start = start;
    assign res.done  = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vced_pkg::ST_IDLE;
            quiet_reg <= '0;
        end
        else if (decide)
        begin
            state_reg <= state_next;
            quiet_reg <= quiet_next;
        end
    end

endmodule
